/* sv/cpt_pkg.sv */
// Shared constants, types and helper functions of the color palette table.
package cpt_pkg;

	// Sizing
	localparam int DEFAULT_DEPTH   = 256;
	localparam int MAX_DEPTH       = 1024;
	localparam int NIDX_W          = $clog2(MAX_DEPTH);
	localparam int POS_W           = $clog2(MAX_DEPTH + 1);
	localparam int DEFAULT_ENTRIES = 64;

	// Request codes
	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_SELECT = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_LOAD   = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	// Cell match modes
	localparam logic MATCH_COLOR = 1'b0;
	localparam logic MATCH_INDEX = 1'b1;

	// Cell write operations
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_APPEND = 2'd1;
	localparam logic [1:0] WR_SHIFT  = 2'd2;
	localparam logic [1:0] WR_LOAD   = 2'd3;

	// One node of the lowest-index search tree
	typedef struct packed {
		logic              hit;
		logic [NIDX_W-1:0] idx;
		logic [31:0]       data;
	} cpt_node_t;

	// Match command broadcast to every cell
	typedef struct packed {
		logic             mode;
		logic [31:0]      key;
		logic [7:0]       target;
		logic [POS_W-1:0] count;
	} cpt_match_t;

	// Write command broadcast to every cell
	typedef struct packed {
		logic [1:0]       op;
		logic [31:0]      data;
		logic [POS_W-1:0] pos;
	} cpt_write_t;

	// Number of 4-way tree levels that cover the given depth
	function automatic int tree_levels(input int depth);
		return ($clog2(depth) + 1) / 2;
	endfunction

	// Default palette entry: r, g, b levels in index bits 5:4, 3:2, 1:0.
	// A level times 85 is the 2-bit level repeated four times.
	function automatic logic [31:0] default_color(input logic [5:0] pos);
		return {8'hFF, {4{pos[1:0]}}, {4{pos[3:2]}}, {4{pos[5:4]}}};
	endfunction

	// Keep the lower-index child when it hits
	function automatic cpt_node_t pick2(input cpt_node_t lo, input cpt_node_t hi);
		return lo.hit ? lo : hi;
	endfunction

	function automatic cpt_node_t pick4(input cpt_node_t a, input cpt_node_t b,
			input cpt_node_t c, input cpt_node_t d);
		return pick2(pick2(a, b), pick2(c, d));
	endfunction

endpackage

/* sv/cpt_req_if.sv */
// Request channel: valid/ready handshake with the request payload.
interface cpt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] color_in;
	logic [7:0]  entry_index;

	modport source (output valid, output req_type, output color_in, output entry_index,
		input ready);
	modport sink (input valid, input req_type, input color_in, input entry_index,
		output ready);
endinterface

/* sv/cpt_rsp_if.sv */
// Response channel: valid/ready handshake with the result payload.
interface cpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  result_index;
	logic [31:0] color_out;
	logic [8:0]  entry_count;
	logic [1:0]  status;

	modport source (output valid, output result_index, output color_out,
		output entry_count, output status, input ready);
	modport sink (input valid, input result_index, input color_out,
		input entry_count, input status, output ready);
endinterface

/* sv/color_palette_table_unit.sv */
// Color palette table: ordered RGBA entries with add, remove, select, read and defaults.
//
// Channels: req (sink) carries req_type, color_in and entry_index; rsp (source)
// returns result_index, color_out, entry_count and status. Both use valid/ready,
// and a transaction completes at a clock edge where both are high.
// Each request yields exactly one response transaction.
// The table is a row of TABLE_DEPTH cells. Every cell compares its entry in
// parallel, and a registered 4-way tree of L = ceil(log4(TABLE_DEPTH)) levels
// picks the lowest-index hit; a remove shifts all later cells down together.
// The response register is loaded once the match has passed the cell registers
// and every tree level. One request is in flight at a time: a new request is
// accepted only after the previous one has left the sequencer.
// A new request is accepted while the previous response still waits in the
// output register; if the receiver stalls, the next response holds until the
// register frees, and no further request is taken meanwhile.
// Reset (arst_n low) empties the table and zeroes the selection; no clearing
// pass is needed, so requests are accepted right after reset.
module color_palette_table_unit #(
	parameter int TABLE_DEPTH = cpt_pkg::DEFAULT_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	cpt_req_if.sink   req,
	cpt_rsp_if.source rsp
);

	localparam int LEAVES = 4 ** cpt_pkg::tree_levels(TABLE_DEPTH);

	cpt_pkg::cpt_match_t match;
	cpt_pkg::cpt_write_t wr;
	cpt_pkg::cpt_node_t  root;
	cpt_pkg::cpt_node_t  leaves [LEAVES];
	logic [31:0]         cell_entry [TABLE_DEPTH];

	// Row of cells, each shifting from its upper neighbor
	for (genvar i = 0; i < LEAVES; i++) begin : g_cell
		if (i < TABLE_DEPTH) begin : g_real
			if (i < TABLE_DEPTH - 1) begin : g_mid
				cpt_cell #(.CELL_IDX(i)) u_cell (
					.clk        (clk),
					.match      (match),
					.wr         (wr),
					.next_entry (cell_entry[i+1]),
					.entry      (cell_entry[i]),
					.leaf       (leaves[i])
				);
			end else begin : g_last
				cpt_cell #(.CELL_IDX(i)) u_cell (
					.clk        (clk),
					.match      (match),
					.wr         (wr),
					.next_entry (cell_entry[i]),
					.entry      (cell_entry[i]),
					.leaf       (leaves[i])
				);
			end
		end else begin : g_pad
			assign leaves[i] = '0;
		end
	end

	cpt_tree #(.DEPTH(TABLE_DEPTH)) u_tree (
		.clk    (clk),
		.leaves (leaves),
		.root   (root)
	);

	cpt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.root   (root),
		.match  (match),
		.wr     (wr)
	);

endmodule

/* sv/cpt_cell.sv */
// One table cell: holds an entry, matches it, and takes its neighbor's entry on a shift.
module cpt_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                  clk,
	input  cpt_pkg::cpt_match_t   match,
	input  cpt_pkg::cpt_write_t   wr,
	input  logic [31:0]           next_entry,
	output logic [31:0]           entry,
	output cpt_pkg::cpt_node_t    leaf
);

	logic [31:0] entry_q;
	logic        hit_q;
	logic        hit_d;

	// Match against the broadcast key or index
	always_comb begin
		unique case (match.mode)
			cpt_pkg::MATCH_COLOR: hit_d = (entry_q == match.key) &&
				(CELL_IDX < int'(match.count));
			cpt_pkg::MATCH_INDEX: hit_d = (int'(match.target) == CELL_IDX);
			default:              hit_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_d;
	end

	// Entry update: append, shift down from the neighbor, or default load
	always_ff @(posedge clk) begin
		unique case (wr.op)
			cpt_pkg::WR_APPEND: begin
				if (int'(wr.pos) == CELL_IDX) entry_q <= wr.data;
			end
			cpt_pkg::WR_SHIFT: begin
				if (int'(wr.pos) <= CELL_IDX) entry_q <= next_entry;
			end
			cpt_pkg::WR_LOAD: begin
				if (CELL_IDX < cpt_pkg::DEFAULT_ENTRIES)
					entry_q <= cpt_pkg::default_color(6'(CELL_IDX));
			end
			default: begin
			end
		endcase
	end

	assign entry     = entry_q;
	assign leaf.hit  = hit_q;
	assign leaf.idx  = cpt_pkg::NIDX_W'(CELL_IDX);
	assign leaf.data = entry_q;

endmodule

/* sv/cpt_tree.sv */
// Registered 4-way tree that finds the lowest-index hitting cell and its entry.
module cpt_tree #(
	parameter int DEPTH = cpt_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  cpt_pkg::cpt_node_t leaves [4 ** cpt_pkg::tree_levels(DEPTH)],
	output cpt_pkg::cpt_node_t root
);

	localparam int LEVELS = cpt_pkg::tree_levels(DEPTH);
	localparam int NODES  = ((4 ** LEVELS) - 1) / 3;

	// Start of a level in the flat node array (level 1 sits right above the leaves)
	function automatic int lvl_off(input int lv);
		int off;
		off = 0;
		for (int k = 1; k < lv; k++) off += 4 ** (LEVELS - k);
		return off;
	endfunction

	cpt_pkg::cpt_node_t nodes_q [NODES];

	for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
		for (genvar n = 0; n < 4 ** (LEVELS - lv); n++) begin : g_node
			if (lv == 1) begin : g_from_leaf
				always_ff @(posedge clk) begin
					nodes_q[lvl_off(lv) + n] <= cpt_pkg::pick4(leaves[4*n], leaves[4*n+1],
						leaves[4*n+2], leaves[4*n+3]);
				end
			end else begin : g_from_node
				always_ff @(posedge clk) begin
					nodes_q[lvl_off(lv) + n] <= cpt_pkg::pick4(
						nodes_q[lvl_off(lv-1) + 4*n],   nodes_q[lvl_off(lv-1) + 4*n+1],
						nodes_q[lvl_off(lv-1) + 4*n+2], nodes_q[lvl_off(lv-1) + 4*n+3]);
				end
			end
		end
	end

	assign root = nodes_q[lvl_off(LEVELS)];

endmodule

/* sv/cpt_ctrl.sv */
// Request sequencer: count, selection, cell commands and the response register.
module cpt_ctrl #(
	parameter int DEPTH = cpt_pkg::DEFAULT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	cpt_req_if.sink             req,
	cpt_rsp_if.source           rsp,
	input  cpt_pkg::cpt_node_t  root,
	output cpt_pkg::cpt_match_t match,
	output cpt_pkg::cpt_write_t wr
);

	localparam int LEVELS = cpt_pkg::tree_levels(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
	localparam int WAIT_W = $clog2(LEVELS + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]          state_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [2:0]          req_q;
	logic [31:0]         color_q;
	logic [7:0]          idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [7:0]          sel_q;
	cpt_pkg::cpt_match_t match_q;

	logic                rsp_valid_q;
	logic [7:0]          res_idx_q;
	logic [31:0]         res_color_q;
	logic [8:0]          res_count_q;
	logic [1:0]          res_status_q;

	logic                accept;
	logic                take;
	logic [CNT_W-1:0]    nxt_count;
	logic [7:0]          nxt_sel;
	logic [7:0]          res_idx;
	logic [31:0]         res_color;
	logic [1:0]          res_status;
	logic [1:0]          wr_op;
	logic [CNT_W-1:0]    wr_pos;
	logic                empty;
	logic                idx_out;
	logic                sel_out;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign take      = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	assign empty   = (count_q == '0);
	assign idx_out = CMP_W'(idx_q) >= CMP_W'(count_q);
	assign sel_out = CMP_W'(sel_q) >= CMP_W'(count_q);

	// Outcome of the request once the tree result is in
	always_comb begin
		nxt_count  = count_q;
		nxt_sel    = sel_q;
		res_idx    = sel_q;
		res_color  = '0;
		res_status = cpt_pkg::STAT_OK;
		wr_op      = cpt_pkg::WR_NONE;
		wr_pos     = count_q;
		unique case (req_q)
			cpt_pkg::REQ_ADD: begin
				if (root.hit) begin
					res_idx = 8'(root.idx);
				end else if (count_q >= CNT_W'(DEPTH)) begin
					res_status = cpt_pkg::STAT_FULL;
				end else begin
					wr_op     = cpt_pkg::WR_APPEND;
					nxt_count = count_q + CNT_W'(1);
					res_idx   = 8'(count_q);
				end
			end
			cpt_pkg::REQ_REMOVE: begin
				if (empty) begin
					res_status = cpt_pkg::STAT_EMPTY;
				end else if (idx_out) begin
					res_status = cpt_pkg::STAT_RANGE;
				end else begin
					wr_op     = cpt_pkg::WR_SHIFT;
					wr_pos    = CNT_W'(idx_q);
					nxt_count = count_q - CNT_W'(1);
					if (sel_q >= idx_q && sel_q != 8'd0) nxt_sel = sel_q - 8'd1;
					res_idx = nxt_sel;
				end
			end
			cpt_pkg::REQ_SELECT: begin
				if (empty) begin
					res_status = cpt_pkg::STAT_EMPTY;
				end else if (idx_out) begin
					res_status = cpt_pkg::STAT_RANGE;
				end else begin
					nxt_sel   = idx_q;
					res_idx   = idx_q;
					res_color = root.data;
				end
			end
			cpt_pkg::REQ_READ: begin
				if (empty) begin
					res_status = cpt_pkg::STAT_EMPTY;
				end else if (sel_out) begin
					res_status = cpt_pkg::STAT_RANGE;
				end else begin
					res_color = root.data;
				end
			end
			cpt_pkg::REQ_LOAD: begin
				wr_op     = cpt_pkg::WR_LOAD;
				nxt_count = CNT_W'(cpt_pkg::DEFAULT_ENTRIES);
			end
			default: begin
			end
		endcase
	end

	// Cell write command is issued only in the cycle the response register is loaded
	assign wr.op   = take ? wr_op : cpt_pkg::WR_NONE;
	assign wr.data = color_q;
	assign wr.pos  = cpt_pkg::POS_W'(wr_pos);
	assign match   = match_q;

	// Sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			count_q <= '0;
			sel_q   <= '0;
			match_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q       <= ST_WAIT;
						wait_q        <= WAIT_W'(LEVELS + 1);
						match_q.mode  <= (req.req_type == cpt_pkg::REQ_ADD) ?
							cpt_pkg::MATCH_COLOR : cpt_pkg::MATCH_INDEX;
						match_q.key   <= req.color_in;
						match_q.target <= (req.req_type == cpt_pkg::REQ_SELECT) ?
							req.entry_index : sel_q;
						match_q.count <= cpt_pkg::POS_W'(count_q);
					end
				end
				ST_WAIT: begin
					if (wait_q == '0) state_q <= ST_RESP;
					else wait_q <= wait_q - WAIT_W'(1);
				end
				ST_RESP: begin
					if (take) begin
						state_q <= ST_IDLE;
						count_q <= nxt_count;
						sel_q   <= nxt_sel;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			color_q <= req.color_in;
			idx_q   <= req.entry_index;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_idx_q    <= res_idx;
			res_color_q  <= res_color;
			res_count_q  <= 9'(nxt_count);
			res_status_q <= res_status;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_index = res_idx_q;
	assign rsp.color_out    = res_color_q;
	assign rsp.entry_count  = res_count_q;
	assign rsp.status       = res_status_q;

endmodule
